// ===== sv/fdpb_pkg.sv =====
// ----------------------------------------------------------------------------
// fdpb_pkg
// shared constants for the pixel budget dimension fitter
// ----------------------------------------------------------------------------
package fdpb_pkg;

  localparam int unsigned DimBitsDefault = 16;
  localparam int unsigned BudgetBits     = 32;

endpackage

// ===== sv/fit_dimensions_to_pixel_budget.sv =====
// ----------------------------------------------------------------------------
// fit_dimensions_to_pixel_budget
// pipeline: DIM_BITS+32 division cells, ceil((DIM_BITS+32)/2) root cells and
// two register stages; throughput one item a cycle when not stalled, and
// the whole cell row stalls together while a result waits at the output
// reset clears the valid chain and the budget register, no clearing pass
// ----------------------------------------------------------------------------
module fit_dimensions_to_pixel_budget #(
  parameter int unsigned DIM_BITS = fdpb_pkg::DimBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fdpb_pkg::BudgetBits-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [DIM_BITS-1:0]             in_width_i,
  input  logic [DIM_BITS-1:0]             in_height_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [DIM_BITS-1:0]             out_width_o,
  output logic [DIM_BITS-1:0]             out_height_o,
  output logic                            was_scaled_o
);

  localparam int unsigned NumBits  = DIM_BITS + fdpb_pkg::BudgetBits;
  localparam int unsigned HalfBits = (NumBits + 1) / 2;
  localparam int unsigned Stages   = NumBits + HalfBits;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic                scaled;
  } side_t;

  logic                            en;
  logic [fdpb_pkg::BudgetBits-1:0] budget_q;

  logic  [Stages:0] vld_q;
  side_t            side_q [Stages+1];

  logic [NumBits-1:0]  dnum_w [NumBits+1];
  logic [DIM_BITS-1:0] ddiv_w [NumBits+1];
  logic [DIM_BITS-1:0] drem_w [NumBits+1];
  logic [NumBits-1:0]  dquo_w [NumBits+1];
  logic [NumBits-1:0]  hnum_w [NumBits+1];
  logic [DIM_BITS-1:0] hdiv_w [NumBits+1];
  logic [DIM_BITS-1:0] hrem_w [NumBits+1];
  logic [NumBits-1:0]  hquo_w [NumBits+1];

  logic [2*HalfBits-1:0] wval_w  [HalfBits+1];
  logic [HalfBits+1:0]   wrem_w  [HalfBits+1];
  logic [HalfBits-1:0]   wroot_w [HalfBits+1];
  logic [2*HalfBits-1:0] hval_w  [HalfBits+1];
  logic [HalfBits+1:0]   hrem_w2 [HalfBits+1];
  logic [HalfBits-1:0]   hroot_w [HalfBits+1];

  logic [NumBits-1:0]    wnum_q, hnum_q;
  logic [2*DIM_BITS-1:0] area;
  side_t                 side_d;

  logic                out_valid_q;
  logic [DIM_BITS-1:0] out_width_q, out_height_q;
  logic                out_scaled_q;
  logic [DIM_BITS-1:0] fw, fh;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  // entry stage: area check and numerators
  assign area          = in_width_i * in_height_i;
  assign side_d.width  = in_width_i;
  assign side_d.height = in_height_i;
  assign side_d.scaled = (budget_q != '0) &&
                         (NumBits'(area) > NumBits'(budget_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      wnum_q    <= NumBits'(in_width_i) * NumBits'(budget_q);
      hnum_q    <= NumBits'(in_height_i) * NumBits'(budget_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-1:0], in_valid_i};
    end
  end

  for (genvar s = 1; s <= Stages; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign dnum_w[0] = wnum_q;
  assign ddiv_w[0] = side_q[0].height;
  assign drem_w[0] = '0;
  assign dquo_w[0] = '0;
  assign hnum_w[0] = hnum_q;
  assign hdiv_w[0] = side_q[0].width;
  assign hrem_w[0] = '0;
  assign hquo_w[0] = '0;

  for (genvar i = 0; i < NumBits; i++) begin : g_div
    fdpb_div_cell #(.DimBits(DIM_BITS), .NumBits(NumBits)) u_wdiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dnum_w[i]),
      .div_i (ddiv_w[i]),
      .rem_i (drem_w[i]),
      .quo_i (dquo_w[i]),
      .num_o (dnum_w[i+1]),
      .div_o (ddiv_w[i+1]),
      .rem_o (drem_w[i+1]),
      .quo_o (dquo_w[i+1])
    );
    fdpb_div_cell #(.DimBits(DIM_BITS), .NumBits(NumBits)) u_hdiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (hnum_w[i]),
      .div_i (hdiv_w[i]),
      .rem_i (hrem_w[i]),
      .quo_i (hquo_w[i]),
      .num_o (hnum_w[i+1]),
      .div_o (hdiv_w[i+1]),
      .rem_o (hrem_w[i+1]),
      .quo_o (hquo_w[i+1])
    );
  end

  assign wval_w[0]  = (2*HalfBits)'(dquo_w[NumBits]);
  assign wrem_w[0]  = '0;
  assign wroot_w[0] = '0;
  assign hval_w[0]  = (2*HalfBits)'(hquo_w[NumBits]);
  assign hrem_w2[0] = '0;
  assign hroot_w[0] = '0;

  for (genvar j = 0; j < HalfBits; j++) begin : g_sqrt
    fdpb_sqrt_cell #(.HalfBits(HalfBits)) u_wsqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (wval_w[j]),
      .rem_i  (wrem_w[j]),
      .root_i (wroot_w[j]),
      .val_o  (wval_w[j+1]),
      .rem_o  (wrem_w[j+1]),
      .root_o (wroot_w[j+1])
    );
    fdpb_sqrt_cell #(.HalfBits(HalfBits)) u_hsqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (hval_w[j]),
      .rem_i  (hrem_w2[j]),
      .root_i (hroot_w[j]),
      .val_o  (hval_w[j+1]),
      .rem_o  (hrem_w2[j+1]),
      .root_o (hroot_w[j+1])
    );
  end

  // scaled sizes rounded down to even
  assign fw = {wroot_w[HalfBits][DIM_BITS-1:1], 1'b0};
  assign fh = {hroot_w[HalfBits][DIM_BITS-1:1], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_scaled_q <= side_q[Stages].scaled;
      out_width_q  <= side_q[Stages].scaled ? fw : side_q[Stages].width;
      out_height_q <= side_q[Stages].scaled ? fh : side_q[Stages].height;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_width_o  = out_width_q;
  assign out_height_o = out_height_q;
  assign was_scaled_o = out_scaled_q;

endmodule

// ===== sv/fdpb_div_cell.sv =====
// ----------------------------------------------------------------------------
// fdpb_div_cell
// one restoring division step, one quotient bit per cell
// ----------------------------------------------------------------------------
module fdpb_div_cell #(
  parameter int unsigned DimBits = fdpb_pkg::DimBitsDefault,
  parameter int unsigned NumBits = fdpb_pkg::DimBitsDefault + fdpb_pkg::BudgetBits
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DimBits-1:0] div_i,
  input  logic [DimBits-1:0] rem_i,
  input  logic [NumBits-1:0] quo_i,
  output logic [NumBits-1:0] num_o,
  output logic [DimBits-1:0] div_o,
  output logic [DimBits-1:0] rem_o,
  output logic [NumBits-1:0] quo_o
);

  logic [DimBits:0]   trial;
  logic               fits;
  logic [NumBits-1:0] num_q;
  logic [DimBits-1:0] div_q;
  logic [DimBits-1:0] rem_q, rem_d;
  logic [NumBits-1:0] quo_q;

  assign trial = {rem_i, num_i[NumBits-1]};
  assign fits  = (trial >= {1'b0, div_i});

  always_comb begin
    if (fits) begin
      rem_d = DimBits'(trial - {1'b0, div_i});
    end else begin
      rem_d = trial[DimBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= {num_i[NumBits-2:0], 1'b0};
      div_q <= div_i;
      rem_q <= rem_d;
      quo_q <= {quo_i[NumBits-2:0], fits};
    end
  end

  assign num_o = num_q;
  assign div_o = div_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ===== sv/fdpb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fdpb_sqrt_cell
// one digit-by-digit square root step, one root bit per cell
// ----------------------------------------------------------------------------
module fdpb_sqrt_cell #(
  parameter int unsigned HalfBits = (fdpb_pkg::DimBitsDefault + fdpb_pkg::BudgetBits + 1) / 2
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*HalfBits-1:0] val_i,
  input  logic [HalfBits+1:0]   rem_i,
  input  logic [HalfBits-1:0]   root_i,
  output logic [2*HalfBits-1:0] val_o,
  output logic [HalfBits+1:0]   rem_o,
  output logic [HalfBits-1:0]   root_o
);

  logic [HalfBits+3:0]   brought;
  logic [HalfBits+3:0]   trial;
  logic                  fits;
  logic [HalfBits+1:0]   rem_d;
  logic [2*HalfBits-1:0] val_q;
  logic [HalfBits+1:0]   rem_q;
  logic [HalfBits-1:0]   root_q;

  assign brought = {rem_i, val_i[2*HalfBits-1 -: 2]};
  assign trial   = {2'b00, root_i, 2'b01};
  assign fits    = (brought >= trial);

  always_comb begin
    if (fits) begin
      rem_d = (HalfBits+2)'(brought - trial);
    end else begin
      rem_d = brought[HalfBits+1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= {val_i[2*HalfBits-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_i[HalfBits-2:0], fits};
    end
  end

  assign val_o  = val_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== sim/fdpb_checker.sv =====
// ----------------------------------------------------------------------------
// fdpb_checker
// watches both channels of the dimension fitter, computes the fitted sizes of
// every accepted item and compares them with each result in order
// ----------------------------------------------------------------------------
module fdpb_checker #(
  parameter int unsigned DIM_BITS = fdpb_pkg::DimBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fdpb_pkg::BudgetBits-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [DIM_BITS-1:0]             in_width_i,
  input  logic [DIM_BITS-1:0]             in_height_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [DIM_BITS-1:0]             out_width_i,
  input  logic [DIM_BITS-1:0]             out_height_i,
  input  logic                            was_scaled_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic                scaled;
  } fitted_t;

  logic [fdpb_pkg::BudgetBits-1:0] budget_q;
  fitted_t                         fitted_q[$];

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] trial;
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic fitted_t fit_sizes(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
                                        logic [fdpb_pkg::BudgetBits-1:0] budget);
    fitted_t     r;
    logic [63:0] area;
    logic [63:0] bound;
    area     = 64'(w) * 64'(h);
    r.width  = w;
    r.height = h;
    r.scaled = 1'b0;
    if (budget != 0 && area > 64'(budget)) begin
      bound    = floor_root((64'(w) * 64'(budget)) / 64'(h));
      r.width  = DIM_BITS'(bound & ~64'd1);
      bound    = floor_root((64'(h) * 64'(budget)) / 64'(w));
      r.height = DIM_BITS'(bound & ~64'd1);
      r.scaled = 1'b1;
    end
    return r;
  endfunction

  assign pending_o = fitted_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    fitted_t want;
    if (!rst_ni) begin
      budget_q     <= '0;
      fail_count_o <= 0;
      fitted_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        fitted_q.push_back(fit_sizes(in_width_i, in_height_i, budget_q));
      if (cfg_we_i) budget_q <= cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (fitted_q.size() == 0) begin
          $display("%0t: unexpected item w=%0d h=%0d s=%0d", $time,
                   out_width_i, out_height_i, was_scaled_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = fitted_q.pop_front();
          if (want.width !== out_width_i || want.height !== out_height_i ||
              want.scaled !== was_scaled_i) begin
            $display("%0t: expected w=%0d h=%0d s=%0d got w=%0d h=%0d s=%0d", $time,
                     want.width, want.height, want.scaled,
                     out_width_i, out_height_i, was_scaled_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives frame sizes through the dimension fitter under several budgets and
// idle patterns; the checker predicts and compares every fitted result
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM_BITS = fdpb_pkg::DimBitsDefault;
  localparam int unsigned LATENCY  = 80;
  localparam int          MAX_CYCLES = 400000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [fdpb_pkg::BudgetBits-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [DIM_BITS-1:0]             in_width_i = '0;
  logic [DIM_BITS-1:0]             in_height_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [DIM_BITS-1:0]             out_width_o;
  logic [DIM_BITS-1:0]             out_height_o;
  logic                            was_scaled_o;
  int                              fail_count;
  int                              pending;
  int                              send_idle_pct = 0;
  int                              stall_pct = 0;
  int                              hold_cycles = 0;
  int                              cycle_count = 0;

  always #5 clk_i = ~clk_i;

  fit_dimensions_to_pixel_budget #(.DIM_BITS(DIM_BITS)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .in_width_i, .in_height_i, .out_valid_o, .out_stall_i, .out_width_o,
    .out_height_o, .was_scaled_o
  );

  fdpb_checker #(.DIM_BITS(DIM_BITS)) checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .in_width_i, .in_height_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_width_i(out_width_o),
    .out_height_i(out_height_o), .was_scaled_i(was_scaled_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_size(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_width_i  <= w;
    in_height_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_budget(logic [fdpb_pkg::BudgetBits-1:0] value);
    drain_all();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DIM_BITS-1:0] random_dim();
    case ($urandom_range(5))
      0: return DIM_BITS'($urandom_range(7));
      1: return DIM_BITS'($urandom_range(2000));
      2: return DIM_BITS'($urandom_range(65535, 60000));
      default: return DIM_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_budget();
    case ($urandom_range(4))
      0: return 32'($urandom_range(16, 1));
      1: return 32'($urandom_range(2000000, 1000));
      2: return 32'hffffffff - 32'($urandom_range(1000));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] budgets[6];
    logic [DIM_BITS-1:0] w;
    budgets = '{32'd0, 32'd1, 32'hffffffff, 32'd2073600, 32'd921600, 32'd4};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed sizes at reset budget, then at the extremes
    for (int b = 0; b < 3; b++) begin
      if (b > 0) write_budget(budgets[b]);
      send_size(0, 0);
      send_size(16'hffff, 16'hffff);
      send_size(0, 16'hffff);
      send_size(16'hffff, 0);
      send_size(1, 1);
      send_size(16'haaaa, 16'h5555);
      send_size(1920, 1080);
    end
    write_budget(32'd4);
    send_size(3, 3);
    send_size(2, 2);
    send_size(16'hffff, 1);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      write_budget(phase < 3 ? budgets[phase + 3] : random_budget());
      if (phase == 0) hold_cycles <= 300;
      for (int i = 0; i < 250; i++) begin
        if (phase == 4 && i == 100) drain_all();
        if ($urandom_range(3) == 0) begin
          w = random_dim();
          send_size(w, DIM_BITS'($urandom_range(2) == 0 ? w : random_dim()));
        end else begin
          send_size(random_dim(), random_dim());
        end
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    drain_all();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== fit_dimensions_to_pixel_budget.f =====
sv/fdpb_pkg.sv
sv/fdpb_div_cell.sv
sv/fdpb_sqrt_cell.sv
sv/fit_dimensions_to_pixel_budget.sv
sim/fdpb_checker.sv
sim/testbench.sv
